/* rtl/tle_pkg.sv */
// shared types, codes and echo string tables for the terminal line editor
`timescale 1ns / 1ps
package tle_pkg;

  localparam int LINE_CAPACITY = 256;                  // entries in the line store
  localparam int PW = $clog2(LINE_CAPACITY + 1);       // width of cursor, count and position
  localparam int SEQ_MAX = 7;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic OPC_KEY  = 1'b0;
  localparam logic OPC_READ = 1'b1;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_SS3   = 8'h4f;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] KEY_LEFT  = 8'h44;
  localparam logic [7:0] KEY_RIGHT = 8'h43;
  localparam logic [7:0] KEY_INS   = 8'h32;
  localparam logic [7:0] KEY_DEL   = 8'h33;
  localparam logic [7:0] KEY_HOME  = 8'h48;
  localparam logic [7:0] KEY_END   = 8'h46;

  typedef enum logic [2:0] {
    OP_READ, OP_STR, OP_BKSP, OP_DEL, OP_INS, OP_ENTER, OP_ERROR, OP_END
  } cmd_op_t;

  typedef enum logic [2:0] {
    STR_LEFT, STR_RIGHT, STR_Q0, STR_Q3, STR_HOME, STR_CLEAR, STR_BKSP, STR_DEL
  } str_id_t;

  typedef struct packed {
    cmd_op_t       op;
    str_id_t       sid;
    logic          flag;    // shift for insert, overwrite for enter
    logic [7:0]    data;    // key byte or read index
    logic [PW-1:0] pos;
    logic [PW-1:0] bound;
  } cmd_t;

  function automatic logic [2:0] str_len(str_id_t id);
    case (id)
      STR_Q0, STR_Q3, STR_CLEAR: str_len = 3'd5;
      STR_HOME:                  str_len = 3'd1;
      STR_BKSP:                  str_len = 3'd6;
      default:                   str_len = 3'd3;
    endcase
  endfunction

  function automatic logic [7:0] str_byte(str_id_t id, logic [2:0] k);
    logic [7:0] b;
    b = 8'h00;
    case (id)
      STR_LEFT:  b = (k == 3'd0) ? CH_ESC : (k == 3'd1) ? CH_LBR : KEY_LEFT;
      STR_RIGHT: b = (k == 3'd0) ? CH_ESC : (k == 3'd1) ? CH_LBR : KEY_RIGHT;
      STR_DEL:   b = (k == 3'd0) ? CH_ESC : (k == 3'd1) ? CH_LBR : 8'h50;
      STR_HOME:  b = CH_CR;
      STR_Q0, STR_Q3: begin
        case (k)
          3'd0:    b = CH_ESC;
          3'd1:    b = CH_LBR;
          3'd2:    b = (id == STR_Q0) ? CH_ZERO : KEY_DEL;
          3'd3:    b = CH_SPACE;
          default: b = 8'h71;
        endcase
      end
      STR_CLEAR: begin
        case (k)
          3'd0:    b = CH_ESC;
          3'd1:    b = CH_LBR;
          3'd2:    b = KEY_INS;
          3'd3:    b = 8'h4b;
          default: b = CH_CR;
        endcase
      end
      default: begin
        case (k)
          3'd0, 3'd3: b = CH_ESC;
          3'd1, 3'd4: b = CH_LBR;
          3'd2:       b = KEY_LEFT;
          default:    b = 8'h50;
        endcase
      end
    endcase
    str_byte = b;
  endfunction

endpackage

/* rtl/tle_if.sv */
// request channel interfaces for key input and results
`timescale 1ns / 1ps
interface tle_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] key_byte;
  logic [7:0] read_index;
  modport source (output valid, opcode, key_byte, read_index, input ready);
  modport sink (input valid, opcode, key_byte, read_index, output ready);
endinterface

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [8:0] line_count;
  logic       last;
  modport source (output valid, kind, out_byte, line_count, last, input ready);
  modport sink (input valid, kind, out_byte, line_count, last, output ready);
endinterface

/* rtl/tle_front.sv */
// front end: decodes keys and escape sequences, keeps cursor state, issues commands
`timescale 1ns / 1ps
module tle_front import tle_pkg::*; #(
  parameter int CSI_MAX_BYTES = 31
) (
  input  logic          clk,
  input  logic          rst,
  tle_in_if.sink        keys,
  input  logic [PW-1:0] limit,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_data
);

  localparam logic [12:0] CAP = 13'(LINE_CAPACITY);
  localparam logic [4:0] CSI_MAX = 5'(CSI_MAX_BYTES);

  typedef enum logic [3:0] {
    ESC_PLAIN = 4'b0001,
    ESC_SEEN  = 4'b0010,
    ESC_CSI   = 4'b0100,
    ESC_SKIP  = 4'b1000
  } esc_t;

  esc_t          esc, esc_next;
  logic [PW-1:0] cursor, cursor_next, count, count_next;
  logic          ovw, ovw_next, finished, finished_next;
  logic [4:0]    csi_len, csi_len_next;
  logic [7:0]    csi_first, csi_first_next;

  logic [PW-1:0] cur_e, cnt_e, lim;
  logic          ovw_e, acc, is_fin;
  logic [7:0]    c, first;
  logic [4:0]    len_inc;

  assign keys.ready = !q_full;
  assign acc = keys.valid && keys.ready;
  assign c = keys.key_byte;
  assign is_fin = (c >= CH_AT) && (c <= CH_TILDE);
  assign lim = (13'(limit) > CAP) ? PW'(CAP) : limit;
  assign len_inc = csi_len + 5'd1;

  always_comb begin
    cur_e = cursor;
    cnt_e = count;
    ovw_e = ovw;
    finished_next = finished;
    if (keys.opcode == OPC_KEY && finished) begin
      cur_e = '0;
      cnt_e = '0;
      ovw_e = 1'b0;
      finished_next = 1'b0;
    end
    cursor_next = cur_e;
    count_next = cnt_e;
    ovw_next = ovw_e;
    esc_next = esc;
    csi_len_next = csi_len;
    csi_first_next = csi_first;
    first = (csi_len == 5'd0) ? c : csi_first;
    q_push = 1'b0;
    q_data.op = OP_STR;
    q_data.sid = STR_LEFT;
    q_data.flag = 1'b0;
    q_data.data = c;
    q_data.pos = cur_e;
    q_data.bound = cnt_e;

    if (keys.opcode == OPC_READ) begin
      q_push = 1'b1;
      q_data.op = OP_READ;
      q_data.data = keys.read_index;
    end else begin
      unique case (esc)
        ESC_PLAIN: begin
          if (c == CH_CR) begin
            q_push = 1'b1;
            q_data.op = OP_ENTER;
            q_data.flag = ovw_e;
            finished_next = 1'b1;
          end else if (c == CH_DEL) begin
            if (cur_e != '0) begin
              q_push = 1'b1;
              q_data.op = OP_BKSP;
              q_data.sid = STR_BKSP;
              q_data.pos = cur_e - 1'b1;
              q_data.bound = cnt_e - 1'b1;
              cursor_next = cur_e - 1'b1;
              count_next = cnt_e - 1'b1;
            end
          end else if (c == CH_ESC) begin
            esc_next = ESC_SEEN;
          end else if (c == CH_FF) begin
            q_push = 1'b1;
            q_data.sid = STR_CLEAR;
            cursor_next = '0;
            count_next = '0;
          end else if (c >= CH_SPACE && cnt_e < lim) begin
            q_push = 1'b1;
            q_data.op = OP_INS;
            q_data.flag = !ovw_e && (cnt_e != cur_e);
            if (!ovw_e || cur_e == cnt_e) count_next = cnt_e + 1'b1;
            cursor_next = cur_e + 1'b1;
          end
        end
        ESC_SEEN: begin
          if (c == CH_LBR) begin
            esc_next = ESC_CSI;
            csi_len_next = '0;
            csi_first_next = '0;
          end else if (c == CH_SS3 || !is_fin) begin
            esc_next = ESC_SKIP;
          end else begin
            esc_next = ESC_PLAIN;
          end
        end
        ESC_CSI: begin
          csi_first_next = first;
          if (!is_fin) begin
            csi_len_next = len_inc;
            if (len_inc >= CSI_MAX) begin
              q_push = 1'b1;
              q_data.op = OP_ERROR;
              esc_next = ESC_PLAIN;
              csi_len_next = '0;
              finished_next = 1'b1;
            end
          end else begin
            esc_next = ESC_PLAIN;
            csi_len_next = '0;
            case (first)
              KEY_LEFT: if (cur_e != '0) begin
                q_push = 1'b1;
                cursor_next = cur_e - 1'b1;
              end
              KEY_RIGHT: if (cur_e < cnt_e) begin
                q_push = 1'b1;
                q_data.sid = STR_RIGHT;
                cursor_next = cur_e + 1'b1;
              end
              KEY_INS: if (csi_len == 5'd1) begin
                q_push = 1'b1;
                q_data.sid = ovw_e ? STR_Q0 : STR_Q3;
                ovw_next = !ovw_e;
              end
              KEY_DEL: if (csi_len == 5'd1 && cur_e < cnt_e) begin
                q_push = 1'b1;
                q_data.op = OP_DEL;
                q_data.sid = STR_DEL;
                q_data.bound = cnt_e - 1'b1;
                count_next = cnt_e - 1'b1;
              end
              KEY_HOME: if (csi_len == 5'd0) begin
                q_push = 1'b1;
                q_data.sid = STR_HOME;
                cursor_next = '0;
              end
              KEY_END: if (csi_len == 5'd0) begin
                q_push = 1'b1;
                q_data.op = OP_END;
                cursor_next = cnt_e;
              end
              default: ;
            endcase
          end
        end
        default: begin
          if (is_fin) esc_next = ESC_PLAIN;
        end
      endcase
    end
    if (!acc) q_push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc <= ESC_PLAIN;
      cursor <= '0;
      count <= '0;
      ovw <= 1'b0;
      finished <= 1'b0;
      csi_len <= '0;
      csi_first <= '0;
    end else if (acc) begin
      esc <= esc_next;
      cursor <= cursor_next;
      count <= count_next;
      ovw <= ovw_next;
      finished <= finished_next;
      csi_len <= csi_len_next;
      csi_first <= csi_first_next;
    end
  end

endmodule

/* rtl/tle_queue.sv */
// two-entry command queue between front and back
`timescale 1ns / 1ps
module tle_queue import tle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t pop_data
);

  cmd_t       slot [2];
  logic       wp, rp;
  logic [1:0] fill;

  assign full = (fill == 2'd2);
  assign avail = (fill != 2'd0);
  assign pop_data = slot[rp];

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

/* rtl/tle_back.sv */
// back end: line store shifts, reads and echo sequencing onto the result channel
`timescale 1ns / 1ps
module tle_back import tle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_avail,
  input  cmd_t       q_data,
  output logic       q_pop,
  tle_out_if.source  results
);

  localparam int DEPTH = LINE_CAPACITY;
  localparam int AW = $clog2(DEPTH);
  localparam logic [12:0] CAP = 13'(LINE_CAPACITY);

  typedef enum logic [8:0] {
    B_IDLE  = 9'b000000001,
    B_SHLRD = 9'b000000010,
    B_SHLWR = 9'b000000100,
    B_SHRRD = 9'b000001000,
    B_SHRWR = 9'b000010000,
    B_PUT   = 9'b000100000,
    B_RDW   = 9'b001000000,
    B_DIGIT = 9'b010000000,
    B_EMIT  = 9'b100000000
  } bst_t;

  bst_t          st;
  cmd_t          cmd;
  logic [PW-1:0] idx;
  logic [9:0]    num;
  logic [2:0]    hun;
  logic [3:0]    ten;
  logic [1:0]    sq_kind [SEQ_MAX];
  logic [7:0]    sq_byte [SEQ_MAX];
  logic [2:0]    sq_len, sq_pos;
  logic [PW-1:0] lcount;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd;

  logic [1:0]    ld_kind [SEQ_MAX];
  logic [7:0]    ld_byte [SEQ_MAX];
  logic [2:0]    ld_len, sl;
  logic [7:0]    dg_byte [SEQ_MAX];
  logic [2:0]    dg_len;
  logic [PW-1:0] idx_inc, idx_dec;
  logic          out_free, emit_go;

  assign idx_inc = idx + 1'b1;
  assign idx_dec = idx - 1'b1;
  assign out_free = !results.valid || results.ready;
  assign emit_go = (st == B_EMIT) && out_free;
  assign q_pop = (st == B_IDLE) && q_avail;

  // echo sequence for a freshly popped command
  always_comb begin
    sl = str_len(q_data.sid);
    for (int k = 0; k < SEQ_MAX; k++) begin
      ld_kind[k] = KIND_ECHO;
      ld_byte[k] = str_byte(q_data.sid, 3'(k));
    end
    ld_len = sl;
    case (q_data.op)
      OP_INS: begin
        ld_byte[0] = q_data.flag ? CH_ESC : q_data.data;
        ld_byte[1] = CH_LBR;
        ld_byte[2] = CH_AT;
        ld_byte[3] = q_data.data;
        ld_len = q_data.flag ? 3'd4 : 3'd1;
      end
      OP_ENTER: begin
        for (int k = 0; k < 5; k++) ld_byte[k] = str_byte(STR_Q0, 3'(k));
        if (q_data.flag) begin
          ld_byte[5] = CH_LF;
          ld_kind[6] = KIND_LINE;
          ld_byte[6] = 8'h00;
          ld_len = 3'd7;
        end else begin
          ld_byte[0] = CH_LF;
          ld_kind[1] = KIND_LINE;
          ld_byte[1] = 8'h00;
          ld_len = 3'd2;
        end
      end
      OP_ERROR: begin
        ld_kind[0] = KIND_ERROR;
        ld_byte[0] = 8'h00;
        ld_len = 3'd1;
      end
      default: ;
    endcase
  end

  // cursor-to-column echo once the digits are known
  always_comb begin
    for (int k = 0; k < SEQ_MAX; k++) dg_byte[k] = CH_G;
    dg_byte[0] = CH_ESC;
    dg_byte[1] = CH_LBR;
    if (hun != 3'd0) begin
      dg_byte[2] = CH_ZERO + 8'(hun);
      dg_byte[3] = CH_ZERO + 8'(ten);
      dg_byte[4] = CH_ZERO + 8'(num);
      dg_len = 3'd6;
    end else if (ten != 4'd0) begin
      dg_byte[2] = CH_ZERO + 8'(ten);
      dg_byte[3] = CH_ZERO + 8'(num);
      dg_len = 3'd5;
    end else begin
      dg_byte[2] = CH_ZERO + 8'(num);
      dg_len = 3'd4;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = AW'(idx);
    wd = rdata;
    ra = AW'(idx_inc);
    unique case (st)
      B_IDLE:  ra = AW'(q_data.data);
      B_SHLWR: we = 1'b1;
      B_SHRRD: ra = AW'(idx_dec);
      B_SHRWR: we = (13'(idx) < CAP);
      B_PUT: begin
        wa = AW'(cmd.pos);
        wd = cmd.data;
        we = (13'(cmd.pos) < CAP);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_IDLE;
      results.valid <= 1'b0;
    end else begin
      if (emit_go) results.valid <= 1'b1;
      else if (results.valid && results.ready) results.valid <= 1'b0;
      unique case (st)
        B_IDLE: if (q_avail) begin
          cmd <= q_data;
          lcount <= q_data.bound;
          sq_kind <= ld_kind;
          sq_byte <= ld_byte;
          sq_len <= ld_len;
          sq_pos <= 3'd0;
          case (q_data.op)
            OP_READ: st <= B_RDW;
            OP_BKSP, OP_DEL: begin
              idx <= q_data.pos;
              if (q_data.pos < q_data.bound && 13'(q_data.pos) + 13'd1 < CAP)
                st <= B_SHLRD;
              else
                st <= B_EMIT;
            end
            OP_INS: begin
              idx <= q_data.bound;
              st <= q_data.flag ? B_SHRRD : B_PUT;
            end
            OP_END: begin
              num <= 10'(q_data.bound) + 10'd1;
              hun <= 3'd0;
              ten <= 4'd0;
              st <= B_DIGIT;
            end
            default: st <= B_EMIT;
          endcase
        end
        B_SHLRD: st <= B_SHLWR;
        B_SHLWR: begin
          idx <= idx_inc;
          if (idx_inc < cmd.bound && 13'(idx_inc) + 13'd1 < CAP) st <= B_SHLRD;
          else st <= B_EMIT;
        end
        B_SHRRD: st <= B_SHRWR;
        B_SHRWR: begin
          idx <= idx_dec;
          st <= (idx_dec > cmd.pos) ? B_SHRRD : B_PUT;
        end
        B_PUT: st <= B_EMIT;
        B_RDW: begin
          sq_kind[0] <= KIND_READ;
          sq_byte[0] <= (13'(cmd.data) < CAP) ? rdata : 8'h00;
          sq_len <= 3'd1;
          st <= B_EMIT;
        end
        B_DIGIT: begin
          if (num >= 10'd100) begin
            num <= num - 10'd100;
            hun <= hun + 3'd1;
          end else if (num >= 10'd10) begin
            num <= num - 10'd10;
            ten <= ten + 4'd1;
          end else begin
            sq_byte <= dg_byte;
            sq_len <= dg_len;
            st <= B_EMIT;
          end
        end
        B_EMIT: if (out_free) begin
          results.kind <= sq_kind[sq_pos];
          results.out_byte <= sq_byte[sq_pos];
          results.line_count <= (sq_kind[sq_pos] == KIND_LINE) ? lcount : '0;
          results.last <= (sq_pos + 3'd1 == sq_len);
          sq_pos <= sq_pos + 3'd1;
          if (sq_pos + 3'd1 == sq_len) st <= B_IDLE;
        end
        default: st <= B_IDLE;
      endcase
    end
  end

endmodule

/* rtl/terminal_line_editor.sv */
// top level of the terminal line editor: channels, register port and submodules
//
//  channel  | dir  | request                               | accepted when
//  ---------+------+---------------------------------------+---------------------
//  keys     | in   | opcode, key_byte, read_index          | valid && ready
//  results  | out  | kind, out_byte, line_count, last      | valid && ready
//  apb      | in   | line_limit at byte address 0          | psel&penable&pwrite
//
//  a key is taken by the front end whenever the command queue has room
//  the back end then moves each line store entry shifted by an insert or delete with
//  one registered read and one write in separate states, and takes the next command
//  only after the last result of the current one; digit conversion for the end key
//  subtracts hundreds and then tens, one step at a time
//  reset is synchronous and clears all control state; the line store is left as is
//  a stalled result channel backs up the queue, after which keys.ready drops
`timescale 1ns / 1ps
module terminal_line_editor import tle_pkg::*; #(
  parameter int CSI_MAX_BYTES = 31
) (
  input  logic        clk,
  input  logic        rst,
  tle_in_if.sink      keys,
  tle_out_if.source   results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [PW-1:0] line_limit;
  logic          q_push, q_full, q_pop, q_avail;
  cmd_t          q_in, q_out;

  // register port, only line_limit lives here
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {23'd0, line_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= 9'd256;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      line_limit <= pwdata[PW-1:0];
    end
  end

  // key decode and cursor bookkeeping
  tle_front #(
    .CSI_MAX_BYTES (CSI_MAX_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .keys   (keys),
    .limit  (line_limit),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // decouples decode from the slow store shifts
  tle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_out)
  );

  // line store and result sequencing
  tle_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule
